### hw/rtl/lorenz_euler_step_assert.svh
// ---------------------------------------------------------------------------
// Lorenz Euler step assertion macros
// Short forms for the concurrent checks of the block, clocked on clk and
// disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef LORENZ_EULER_STEP_ASSERT_SVH
`define LORENZ_EULER_STEP_ASSERT_SVH

// Same-cycle implication.
`define LEE_ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("lorenz_euler_step: assertion failed");

// Next-cycle implication.
`define LEE_ASSERT_NXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("lorenz_euler_step: assertion failed");

`endif

### hw/rtl/lee_pkg.sv
// ---------------------------------------------------------------------------
// Lorenz Euler step package
// Register indexes, reset values, the configuration record and the
// saturating Q8.24 helpers shared by the modules of the block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lee_pkg;

    localparam int unsigned DataW  = 32;
    localparam int unsigned TsW    = 31;
    localparam int unsigned CountW = 16;
    localparam int unsigned IndexW = 4;
    localparam int unsigned QFrac  = 24;

    localparam logic [IndexW-1:0] REG_SIGMA     = 4'd0;
    localparam logic [IndexW-1:0] REG_RHO       = 4'd1;
    localparam logic [IndexW-1:0] REG_BETA      = 4'd2;
    localparam logic [IndexW-1:0] REG_TIME_STEP = 4'd3;
    localparam logic [IndexW-1:0] REG_START_X   = 4'd4;
    localparam logic [IndexW-1:0] REG_START_Y   = 4'd5;
    localparam logic [IndexW-1:0] REG_START_Z   = 4'd6;
    localparam logic [IndexW-1:0] REG_STEPS     = 4'd7;

    localparam logic signed [DataW-1:0] RST_SIGMA   = 32'sd167772160;
    localparam logic signed [DataW-1:0] RST_RHO     = 32'sd469762048;
    localparam logic signed [DataW-1:0] RST_BETA    = 32'sd44739243;
    localparam logic [TsW-1:0]          RST_TS      = 31'd167772;
    localparam logic signed [DataW-1:0] RST_START_X = 32'sd1677722;
    localparam logic signed [DataW-1:0] RST_START_Y = 32'sd0;
    localparam logic signed [DataW-1:0] RST_START_Z = 32'sd0;
    localparam logic [CountW-1:0]       RST_STEPS   = 16'd1000;

    typedef struct packed {
        logic signed [DataW-1:0] sigma;
        logic signed [DataW-1:0] rho;
        logic signed [DataW-1:0] beta;
        logic [TsW-1:0]          time_step;
        logic signed [DataW-1:0] start_x;
        logic signed [DataW-1:0] start_y;
        logic signed [DataW-1:0] start_z;
        logic [CountW-1:0]       steps_per_run;
    } lee_cfg_t;

    function automatic logic signed [DataW-1:0] sat33(input logic signed [DataW:0] s);
        logic signed [DataW-1:0] r;
        if (s[DataW] != s[DataW-1])
        begin
            r = s[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
        end
        else
        begin
            r = s[DataW-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [DataW-1:0] sat_add(input logic signed [DataW-1:0] a,
                                                        input logic signed [DataW-1:0] b);
        logic signed [DataW:0] s;
        s = {a[DataW-1], a} + {b[DataW-1], b};
        return sat33(s);
    endfunction

    function automatic logic signed [DataW-1:0] sat_sub(input logic signed [DataW-1:0] a,
                                                        input logic signed [DataW-1:0] b);
        logic signed [DataW:0] s;
        s = {a[DataW-1], a} - {b[DataW-1], b};
        return sat33(s);
    endfunction

    // Shift a full product down by the fraction width, rounding toward zero,
    // and saturate to the coordinate format.
    function automatic logic signed [DataW-1:0] q_trunc(input logic signed [2*DataW-1:0] p);
        logic signed [2*DataW-1:0]       adj;
        logic signed [2*DataW-QFrac-1:0] sh;
        logic signed [DataW-1:0]         r;
        adj = p + (p[2*DataW-1] ? {{(2*DataW-QFrac){1'b0}}, {QFrac{1'b1}}}
                                : {(2*DataW){1'b0}});
        sh  = adj[2*DataW-1:QFrac];
        if ((&sh[2*DataW-QFrac-1:DataW-1]) || !(|sh[2*DataW-QFrac-1:DataW-1]))
        begin
            r = sh[DataW-1:0];
        end
        else
        begin
            r = sh[2*DataW-QFrac-1] ? {1'b1, {(DataW-1){1'b0}}}
                                     : {1'b0, {(DataW-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

### hw/rtl/lorenz_euler_step.sv
// ---------------------------------------------------------------------------
// Lorenz Euler step
// One forward Euler step of the Lorenz system per input transaction, in
// signed Q8.24 with saturation, computed on one shared multiplier.
// ---------------------------------------------------------------------------
//  Channel  Handshake             Payload
//  in       in_valid / in_ready   restart
//  out      out_valid / out_ready next_x, next_y, next_z, last
//  cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
//  An item runs seven multiplications in turn on the shared multiplier,
//  each issued in ST_ISSUE and awaited in ST_WAIT, and then writes the
//  result register in ST_FINISH. The next item is accepted only once the
//  block is back in ST_IDLE, so items do not overlap.
//  The input is ready only between items; the result register lets the next
//  item be accepted while a result still waits, and a stalled output holds
//  the following item at its final cycle. Reset loads the default registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lorenz_euler_step_assert.svh"

module lorenz_euler_step
    import lee_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [IndexW-1:0]       cfg_index,
    input  logic [DataW-1:0]        cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    restart,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [DataW-1:0] next_x,
    output logic signed [DataW-1:0] next_y,
    output logic signed [DataW-1:0] next_z,
    output logic                    last
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_ISSUE  = 2'd1;
    localparam logic [1:0] ST_WAIT   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam logic [2:0] OP_A   = 3'd0;
    localparam logic [2:0] OP_NX  = 3'd1;
    localparam logic [2:0] OP_PY  = 3'd2;
    localparam logic [2:0] OP_NY  = 3'd3;
    localparam logic [2:0] OP_PXY = 3'd4;
    localparam logic [2:0] OP_BZ  = 3'd5;
    localparam logic [2:0] OP_NZ  = 3'd6;

    lee_cfg_t                cfg;
    logic [1:0]              state_reg;
    logic [1:0]              state_next;
    logic [2:0]              op_reg;
    logic [2:0]              op_next;
    logic signed [DataW-1:0] px_reg;
    logic signed [DataW-1:0] py_reg;
    logic signed [DataW-1:0] pz_reg;
    logic [CountW-1:0]       cnt_reg;
    logic signed [DataW-1:0] t_reg;
    logic signed [DataW-1:0] nx_reg;
    logic signed [DataW-1:0] ny_reg;
    logic signed [DataW-1:0] nz_reg;
    logic                    out_valid_reg;
    logic signed [DataW-1:0] out_x_reg;
    logic signed [DataW-1:0] out_y_reg;
    logic signed [DataW-1:0] out_z_reg;
    logic                    last_reg;
    logic signed [DataW-1:0] ts_s;
    logic signed [DataW-1:0] mul_a;
    logic signed [DataW-1:0] mul_b;
    logic                    mul_issue;
    logic                    mul_done;
    logic signed [DataW-1:0] mul_res;
    logic [CountW:0]         cnt_plus;
    logic                    run_end;
    logic                    load_out;
    logic                    in_take;

    lee_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lee_mul_unit u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .issue  (mul_issue),
        .op_a   (mul_a),
        .op_b   (mul_b),
        .done   (mul_done),
        .result (mul_res)
    );

    assign ts_s      = {1'b0, cfg.time_step};
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_take   = in_valid && in_ready;
    assign mul_issue = (state_reg == ST_ISSUE);
    assign cnt_plus  = {1'b0, cnt_reg} + {{CountW{1'b0}}, 1'b1};
    assign run_end   = (cnt_plus >= {1'b0, cfg.steps_per_run});
    assign load_out  = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    always_comb
    begin
        case (op_reg)
            OP_A:
            begin
                mul_a = ts_s;
                mul_b = cfg.sigma;
            end
            OP_NX:
            begin
                mul_a = t_reg;
                mul_b = sat_sub(py_reg, px_reg);
            end
            OP_PY:
            begin
                mul_a = px_reg;
                mul_b = sat_sub(cfg.rho, pz_reg);
            end
            OP_NY:
            begin
                mul_a = ts_s;
                mul_b = sat_sub(t_reg, py_reg);
            end
            OP_PXY:
            begin
                mul_a = px_reg;
                mul_b = py_reg;
            end
            OP_BZ:
            begin
                mul_a = cfg.beta;
                mul_b = pz_reg;
            end
            OP_NZ:
            begin
                mul_a = ts_s;
                mul_b = t_reg;
            end
            default:
            begin
                mul_a = ts_s;
                mul_b = t_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_ISSUE;
                    op_next    = OP_A;
                end
            end
            ST_ISSUE:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (mul_done)
                begin
                    if (op_reg == OP_NZ)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_ISSUE;
                        op_next    = op_reg + 3'd1;
                    end
                end
            end
            ST_FINISH:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_A;
            out_valid_reg <= 1'b0;
            px_reg        <= RST_START_X;
            py_reg        <= RST_START_Y;
            pz_reg        <= RST_START_Z;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (in_take && restart)
            begin
                px_reg  <= cfg.start_x;
                py_reg  <= cfg.start_y;
                pz_reg  <= cfg.start_z;
                cnt_reg <= '0;
            end
            else if (load_out)
            begin
                if (run_end)
                begin
                    px_reg  <= cfg.start_x;
                    py_reg  <= cfg.start_y;
                    pz_reg  <= cfg.start_z;
                    cnt_reg <= '0;
                end
                else
                begin
                    px_reg  <= nx_reg;
                    py_reg  <= ny_reg;
                    pz_reg  <= nz_reg;
                    cnt_reg <= cnt_plus[CountW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_done)
        begin
            case (op_reg)
                OP_A:    t_reg  <= mul_res;
                OP_NX:   nx_reg <= sat_add(px_reg, mul_res);
                OP_PY:   t_reg  <= mul_res;
                OP_NY:   ny_reg <= sat_add(py_reg, mul_res);
                OP_PXY:  t_reg  <= mul_res;
                OP_BZ:   t_reg  <= sat_sub(t_reg, mul_res);
                OP_NZ:   nz_reg <= sat_add(pz_reg, mul_res);
                default: t_reg  <= mul_res;
            endcase
        end
        if (load_out)
        begin
            out_x_reg <= nx_reg;
            out_y_reg <= ny_reg;
            out_z_reg <= nz_reg;
            last_reg  <= run_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign next_x    = out_x_reg;
    assign next_y    = out_y_reg;
    assign next_z    = out_z_reg;
    assign last      = last_reg;

    `LEE_ASSERT_IMP(a_mul_done_in_wait, mul_done, state_reg == ST_WAIT)
    `LEE_ASSERT_IMP(a_op_in_range, state_reg == ST_WAIT, op_reg <= OP_NZ)
    `LEE_ASSERT_NXT(a_finish_loads_out, state_reg == ST_FINISH && !out_valid_reg,
                    out_valid_reg && state_reg == ST_IDLE)
    `LEE_ASSERT_IMP(a_last_reloads, $rose(out_valid_reg) && last_reg, cnt_reg == '0)

endmodule

### hw/rtl/lee_cfg_regs.sv
// ---------------------------------------------------------------------------
// Lorenz Euler step configuration registers
// Holds the coefficients, time step, start point and run length, written
// one register per transaction on the configuration channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lee_cfg_regs
    import lee_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [IndexW-1:0]   cfg_index,
    input  logic [DataW-1:0]    cfg_data,
    output lee_cfg_t            cfg
);

    lee_cfg_t cfg_reg;
    lee_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_SIGMA:     cfg_next.sigma         = cfg_data;
                REG_RHO:       cfg_next.rho           = cfg_data;
                REG_BETA:      cfg_next.beta          = cfg_data;
                REG_TIME_STEP: cfg_next.time_step     = cfg_data[TsW-1:0];
                REG_START_X:   cfg_next.start_x       = cfg_data;
                REG_START_Y:   cfg_next.start_y       = cfg_data;
                REG_START_Z:   cfg_next.start_z       = cfg_data;
                REG_STEPS:     cfg_next.steps_per_run = cfg_data[CountW-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sigma         <= RST_SIGMA;
            cfg_reg.rho           <= RST_RHO;
            cfg_reg.beta          <= RST_BETA;
            cfg_reg.time_step     <= RST_TS;
            cfg_reg.start_x       <= RST_START_X;
            cfg_reg.start_y       <= RST_START_Y;
            cfg_reg.start_z       <= RST_START_Z;
            cfg_reg.steps_per_run <= RST_STEPS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hw/rtl/lee_mul_unit.sv
// ---------------------------------------------------------------------------
// Lorenz Euler step shared multiplier
// Three-stage Q8.24 multiplier: operand capture, full signed product, then
// truncation toward zero with saturation.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lee_mul_unit
    import lee_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    issue,
    input  logic signed [DataW-1:0] op_a,
    input  logic signed [DataW-1:0] op_b,
    output logic                    done,
    output logic signed [DataW-1:0] result
);

    logic                      v_reg [3];
    logic signed [DataW-1:0]   a_reg;
    logic signed [DataW-1:0]   b_reg;
    logic signed [2*DataW-1:0] prod_reg;
    logic signed [DataW-1:0]   res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
            v_reg[1] <= 1'b0;
            v_reg[2] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= issue;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= v_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            a_reg <= op_a;
            b_reg <= op_b;
        end
        if (v_reg[0])
        begin
            prod_reg <= a_reg * b_reg;
        end
        if (v_reg[1])
        begin
            res_reg <= q_trunc(prod_reg);
        end
    end

    assign done   = v_reg[2];
    assign result = res_reg;

endmodule

### dv/lorenz_euler_step_tb.sv
// ---------------------------------------------------------------------------
// Lorenz Euler step testbench
// Drives integration ticks with random restarts through the input channel.
// A scoreboard class predicts each new point and the end-of-run flag in
// saturating Q8.24 and checks every result transaction in order. Registers
// are rewritten between phases while the block is idle: directed cases
// first, extremes among them, then random phases. Both channels idle and
// stall at random, except in one long phase where they run without gaps.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lorenz_euler_step_tb;

    import lee_pkg::*;

    typedef enum int {MODE_PHYSICAL, MODE_RANDOM, MODE_EXTREME} phase_mode_t;

    class lorenz_scoreboard;

        typedef struct {
            logic signed [DataW-1:0] x;
            logic signed [DataW-1:0] y;
            logic signed [DataW-1:0] z;
            logic                    last;
        } point_t;

        longint      sigma_q, rho_q, beta_q, dt_q;
        longint      start_x_q, start_y_q, start_z_q;
        int unsigned run_len;
        longint      pos_x, pos_y, pos_z;
        int unsigned step_no;
        point_t      pending_q[$];
        int          errors, items, results, run_ends, reg_writes;

        function new();
            sigma_q   = RST_SIGMA;
            rho_q     = RST_RHO;
            beta_q    = RST_BETA;
            dt_q      = RST_TS;
            start_x_q = RST_START_X;
            start_y_q = RST_START_Y;
            start_z_q = RST_START_Z;
            run_len   = RST_STEPS;
            restart_run();
        endfunction

        function void restart_run();
            pos_x   = start_x_q;
            pos_y   = start_y_q;
            pos_z   = start_z_q;
            step_no = 0;
        endfunction

        function longint clamp(longint v);
            if (v > 64'sd2147483647)
            begin
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648)
            begin
                return -64'sd2147483648;
            end
            return v;
        endfunction

        function longint fx_mul(longint a, longint b);
            longint prod;
            prod = a * b;
            return clamp(prod / (longint'(1) << QFrac));
        endfunction

        function void write_reg(logic [IndexW-1:0] idx, logic [DataW-1:0] d);
            reg_writes++;
            case (idx)
                REG_SIGMA:     sigma_q = $signed(d);
                REG_RHO:       rho_q = $signed(d);
                REG_BETA:      beta_q = $signed(d);
                REG_TIME_STEP: dt_q = d[TsW-1:0];
                REG_START_X:   start_x_q = $signed(d);
                REG_START_Y:   start_y_q = $signed(d);
                REG_START_Z:   start_z_q = $signed(d);
                REG_STEPS:     run_len = d[CountW-1:0];
                default:       ;
            endcase
        endfunction

        function void note_input(bit rs);
            longint x, y, z, nx, ny, nz, a, p, b;
            bit     fin;
            point_t e;
            if (rs)
            begin
                restart_run();
            end
            x = pos_x;
            y = pos_y;
            z = pos_z;
            a  = fx_mul(dt_q, sigma_q);
            nx = clamp(x + fx_mul(a, clamp(y - x)));
            p  = fx_mul(x, clamp(rho_q - z));
            ny = clamp(y + fx_mul(dt_q, clamp(p - y)));
            p  = fx_mul(x, y);
            b  = fx_mul(beta_q, z);
            nz = clamp(z + fx_mul(dt_q, clamp(p - b)));
            fin = (step_no + 1) >= run_len;
            if (fin)
            begin
                restart_run();
                run_ends++;
            end
            else
            begin
                pos_x = nx;
                pos_y = ny;
                pos_z = nz;
                step_no++;
            end
            e.x    = nx[DataW-1:0];
            e.y    = ny[DataW-1:0];
            e.z    = nz[DataW-1:0];
            e.last = fin;
            pending_q.push_back(e);
            items++;
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 50)
            begin
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            end
        endtask

        task check_result(logic signed [DataW-1:0] x, logic signed [DataW-1:0] y,
                          logic signed [DataW-1:0] z, logic l);
            point_t e;
            if (pending_q.size() == 0)
            begin
                report_mismatch("result transaction with no step outstanding");
                return;
            end
            e = pending_q.pop_front();
            results++;
            if (x !== e.x)
            begin
                report_mismatch($sformatf("result %0d next_x %0d, expected %0d",
                                          results, x, e.x));
            end
            if (y !== e.y)
            begin
                report_mismatch($sformatf("result %0d next_y %0d, expected %0d",
                                          results, y, e.y));
            end
            if (z !== e.z)
            begin
                report_mismatch($sformatf("result %0d next_z %0d, expected %0d",
                                          results, z, e.z));
            end
            if (l !== e.last)
            begin
                report_mismatch($sformatf("result %0d last %b, expected %b",
                                          results, l, e.last));
            end
        endtask

    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [IndexW-1:0]       cfg_index = '0;
    logic [DataW-1:0]        cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic                    restart = 1'b0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [DataW-1:0] next_x;
    logic signed [DataW-1:0] next_y;
    logic signed [DataW-1:0] next_z;
    logic                    last;

    bit                      gap_free = 1'b0;
    lorenz_scoreboard        sb;

    lorenz_euler_step uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .restart   (restart),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .next_x    (next_x),
        .next_y    (next_y),
        .next_z    (next_z),
        .last      (last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= gap_free || ($urandom_range(0, 99) >= 33);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result(next_x, next_y, next_z, last);
        end
    end

    task automatic set_reg(input logic [IndexW-1:0] idx, input logic [DataW-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, d);
    endtask

    task automatic send_step(input bit rs);
        cfg_valid <= 1'b0;
        while (!gap_free && $urandom_range(0, 99) < 33)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        restart  <= rs;
        do @(posedge clk); while (!in_ready);
        sb.note_input(rs);
    endtask

    task automatic settle_block();
        in_valid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
    endtask

    initial
    begin
        phase_mode_t      mode;
        logic [DataW-1:0] val;
        int               phase;
        int               r;

        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration.
        send_step(1'b0);
        send_step(1'b0);
        send_step(1'b0);
        send_step(1'b1);

        // A zero run length ends every run after one step.
        settle_block();
        set_reg(REG_STEPS, '0);
        send_step(1'b0);
        send_step(1'b1);

        // Coefficients and start point at the format limits.
        settle_block();
        set_reg(REG_SIGMA, 32'h7FFF_FFFF);
        set_reg(REG_RHO, 32'h8000_0000);
        set_reg(REG_BETA, 32'h7FFF_FFFF);
        set_reg(REG_TIME_STEP, 32'hFFFF_FFFF);
        set_reg(REG_START_X, 32'h7FFF_FFFF);
        set_reg(REG_START_Y, 32'h8000_0000);
        set_reg(REG_START_Z, 32'h7FFF_FFFF);
        set_reg(REG_STEPS, 32'd3);
        send_step(1'b1);
        send_step(1'b0);
        send_step(1'b0);
        send_step(1'b0);

        settle_block();
        set_reg(REG_SIGMA, 32'h8000_0000);
        set_reg(REG_RHO, 32'h7FFF_FFFF);
        set_reg(REG_BETA, 32'h8000_0000);
        set_reg(REG_TIME_STEP, '0);
        set_reg(REG_START_X, 32'h8000_0000);
        set_reg(REG_START_Y, 32'h7FFF_FFFF);
        set_reg(REG_START_Z, 32'h8000_0000);
        send_step(1'b1);
        send_step(1'b0);

        // Run length lowered part way through a run.
        settle_block();
        set_reg(REG_SIGMA, RST_SIGMA);
        set_reg(REG_RHO, RST_RHO);
        set_reg(REG_BETA, RST_BETA);
        set_reg(REG_TIME_STEP, DataW'(RST_TS));
        set_reg(REG_START_X, RST_START_X);
        set_reg(REG_START_Y, 32'h0100_0000);
        set_reg(REG_START_Z, '0);
        set_reg(REG_STEPS, 32'd10);
        send_step(1'b1);
        send_step(1'b0);
        send_step(1'b0);
        send_step(1'b0);
        settle_block();
        set_reg(REG_STEPS, 32'd2);
        send_step(1'b0);

        // Start point changed mid-run is picked up when the run ends.
        settle_block();
        set_reg(REG_STEPS, 32'd3);
        send_step(1'b1);
        settle_block();
        set_reg(REG_START_X, 32'hF000_0000);
        set_reg(REG_START_Z, 32'h1000_0000);
        send_step(1'b0);
        send_step(1'b0);
        send_step(1'b0);

        // Writes to unused register indexes must be ignored.
        settle_block();
        set_reg(REG_STEPS + IndexW'($urandom_range(1, 8)), $urandom());
        set_reg(REG_STEPS + IndexW'($urandom_range(1, 8)), $urandom());
        send_step(1'b0);
        send_step(1'b0);

        phase = 0;
        while (sb.items < 680)
        begin
            settle_block();
            gap_free = (phase == 2);
            r = $urandom_range(0, 9);
            mode = (r < 6) ? MODE_PHYSICAL : (r < 8) ? MODE_RANDOM : MODE_EXTREME;
            for (int k = 0; k <= int'(REG_STEPS); k++)
            begin
                val = $urandom();
                case (mode)
                    MODE_PHYSICAL:
                    begin
                        case (IndexW'(k))
                            REG_SIGMA:
                                val = DataW'($urandom_range(5, 15) << QFrac)
                                      + DataW'($urandom_range(0, 24'hFF_FFFF));
                            REG_RHO:
                                val = DataW'($urandom_range(0, 45) << QFrac)
                                      + DataW'($urandom_range(0, 24'hFF_FFFF));
                            REG_BETA:
                                val = DataW'($urandom_range(1, 4) << QFrac)
                                      + DataW'($urandom_range(0, 24'hFF_FFFF));
                            REG_TIME_STEP:
                                val = DataW'($urandom_range(0, 838861));
                            REG_STEPS:
                            begin
                                r = $urandom_range(0, 19);
                                val = (r == 0) ? '0 :
                                      (r < 3)  ? DataW'($urandom_range(41, 65535)) :
                                                 DataW'($urandom_range(1, 40));
                            end
                            default:
                                val = DataW'(int'($urandom_range(0, 671088640)) - 335544320);
                        endcase
                        set_reg(IndexW'(k), val);
                    end
                    MODE_EXTREME:
                    begin
                        case ($urandom_range(0, 5))
                            0: val = 32'h8000_0000;
                            1: val = 32'h7FFF_FFFF;
                            2: val = '0;
                            3: val = 32'hFFFF_FFFF;
                            4: val = 32'd1;
                            default: val = 32'h0100_0000;
                        endcase
                        set_reg(IndexW'(k), val);
                    end
                    default:
                    begin
                        if ($urandom_range(0, 1) == 1)
                        begin
                            set_reg(IndexW'(k), val);
                        end
                    end
                endcase
            end
            if ($urandom_range(0, 4) == 0)
            begin
                set_reg(REG_STEPS + IndexW'($urandom_range(1, 8)), $urandom());
            end
            repeat (gap_free ? 80 : $urandom_range(10, 50))
            begin
                send_step($urandom_range(0, 99) < 8);
            end
            phase++;
        end
        gap_free = 1'b0;

        settle_block();
        if (sb.pending_q.size() != 0)
        begin
            sb.report_mismatch("steps left without a result");
        end
        $display("Ran %0d Euler steps over %0d phases, %0d runs ended, %0d register writes.",
                 sb.items, phase, sb.run_ends, sb.reg_writes);
        $display("Checked %0d result transactions, %0d mismatches.", sb.results, sb.errors);
        if (sb.errors == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Timeout: the block stopped responding.");
        $display("Test completed with failures");
        $finish;
    end

endmodule
